FILE: rtl/mep_pkg.sv
// Shared types, constants and a helper function of the midpoint ellipse plotter.
package mep_pkg;

    localparam int MAX_RADIUS  = 31;
    localparam int COORD_MAX   = 1023;
    localparam int QUEUE_DEPTH = 2;

    // Field widths fixed by the command and result formats.
    localparam int COORD_W  = 10;
    localparam int RADIUS_W = 5;
    localparam int GLYPH_W  = 8;
    localparam int OUT_W    = 12;
    localparam int MASK_W   = 4;
    localparam int SQ_W     = 2 * RADIUS_W;
    localparam int SLOPE_W  = 20;
    localparam int DEC_W    = 28;
    localparam int OFS_W    = 7;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 64;

    // Saturation limits; an input field can never exceed its own width.
    localparam int RADIUS_LIM = (MAX_RADIUS < (1 << RADIUS_W) - 1) ?
                                MAX_RADIUS : (1 << RADIUS_W) - 1;
    localparam int COORD_LIM  = (COORD_MAX < (1 << COORD_W) - 1) ?
                                COORD_MAX : (1 << COORD_W) - 1;
    localparam int RESULT_CAP = 2 * MAX_RADIUS + 1;
    localparam int CNT_W      = $clog2(RESULT_CAP + 1);

    // One classified command as it waits in the queue.
    typedef struct packed {
        logic [COORD_W-1:0]        cx;
        logic [COORD_W-1:0]        cy;
        logic [SQ_W-1:0]           rx2;
        logic [SQ_W-1:0]           ry2;
        logic [2*SQ_W-1:0]         rxry2;
        logic [RADIUS_W-1:0]       ry;
        logic signed [SLOPE_W-1:0] py0;
        logic signed [DEC_W-1:0]   p0;
        logic [GLYPH_W-1:0]        glyph;
    } mep_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } mep_qstat_t;

    // Division by four that truncates toward zero.
    function automatic logic signed [DEC_W-1:0] div4_trunc(input logic signed [DEC_W-1:0] v);
        logic signed [DEC_W-1:0] adj;
        adj = v[DEC_W-1] ? (v + DEC_W'(3)) : v;
        return adj >>> 2;
    endfunction

endpackage

FILE: rtl/mep_front.sv
// Command front end: takes a command beat, saturates it and forms the squares and start values.
module mep_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [39:0]       s_tdata,   // center_x, center_y, radius_x, radius_y, glyph
    input  mep_pkg::mep_qstat_t q_stat,
    output logic              q_push,
    output mep_pkg::mep_cmd_t q_wdata
);
    import mep_pkg::*;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_SQR  = 4'b0010,
        F_PROD = 4'b0100,
        F_PUSH = 4'b1000
    } front_state_t;

    front_state_t state_reg, state_next;

    logic [COORD_W-1:0]  cx_reg, cy_reg;
    logic [RADIUS_W-1:0] rx_reg, ry_reg;
    logic [GLYPH_W-1:0]  glyph_reg;
    logic [SQ_W-1:0]     rx2_reg, ry2_reg;
    logic [SQ_W+RADIUS_W-1:0] rx2ry_reg;
    logic [2*SQ_W-1:0]   rxry2_reg;

    logic [COORD_W-1:0]  in_cx, in_cy;
    logic [RADIUS_W-1:0] in_rx, in_ry;
    logic signed [DEC_W-1:0] p0_sum;

    assign in_cx = s_tdata[9:0];
    assign in_cy = s_tdata[19:10];
    assign in_rx = s_tdata[24:20];
    assign in_ry = s_tdata[29:25];

    assign s_tready = (state_reg == F_IDLE);
    assign q_push   = (state_reg == F_PUSH) && !q_stat.full;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: if (s_tvalid) state_next = F_SQR;
            F_SQR:  state_next = F_PROD;
            F_PROD: state_next = F_PUSH;
            F_PUSH: if (!q_stat.full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cx_reg    <= (in_cx > COORD_W'(COORD_LIM)) ? COORD_W'(COORD_LIM) : in_cx;
            cy_reg    <= (in_cy > COORD_W'(COORD_LIM)) ? COORD_W'(COORD_LIM) : in_cy;
            rx_reg    <= (in_rx > RADIUS_W'(RADIUS_LIM)) ? RADIUS_W'(RADIUS_LIM) : in_rx;
            ry_reg    <= (in_ry > RADIUS_W'(RADIUS_LIM)) ? RADIUS_W'(RADIUS_LIM) : in_ry;
            glyph_reg <= s_tdata[37:30];
        end
        if (state_reg == F_SQR) begin
            rx2_reg <= rx_reg * rx_reg;
            ry2_reg <= ry_reg * ry_reg;
        end
        if (state_reg == F_PROD) begin
            rx2ry_reg <= rx2_reg * ry_reg;
            rxry2_reg <= rx2_reg * ry2_reg;
        end
    end

    // Four times the region-one start value: 4*ry^2 - 4*rx^2*ry + rx^2.
    assign p0_sum = $signed(DEC_W'({ry2_reg, 2'b00}))
                  - $signed(DEC_W'({rx2ry_reg, 2'b00}))
                  + $signed(DEC_W'(rx2_reg));

    always_comb begin
        q_wdata.cx    = cx_reg;
        q_wdata.cy    = cy_reg;
        q_wdata.rx2   = rx2_reg;
        q_wdata.ry2   = ry2_reg;
        q_wdata.rxry2 = rxry2_reg;
        q_wdata.ry    = ry_reg;
        q_wdata.py0   = $signed(SLOPE_W'({rx2ry_reg, 1'b0}));
        q_wdata.p0    = div4_trunc(p0_sum);
        q_wdata.glyph = glyph_reg;
    end

endmodule

FILE: rtl/mep_queue.sv
// Short command queue between the front end and the walker.
module mep_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  mep_pkg::mep_cmd_t   wdata,
    input  logic                pop,
    output mep_pkg::mep_cmd_t   rdata,
    output mep_pkg::mep_qstat_t stat
);
    import mep_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    mep_cmd_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_QW-1:0]   count_reg;

    assign rdata      = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_QW'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: rtl/mep_walker.sv
// Two-region midpoint walk with a registered result beat.
module mep_walker (
    input  logic                aclk,
    input  logic                aresetn,
    input  mep_pkg::mep_qstat_t q_stat,
    input  mep_pkg::mep_cmd_t   q_rdata,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [63:0]         m_tdata,   // right_x, left_x, lower_y, upper_y, visible_mask, glyph_out
    output logic                m_tlast
);
    import mep_pkg::*;

    typedef enum logic [3:0] {
        W_IDLE  = 4'b0001,
        W_REG1  = 4'b0010,
        W_INIT2 = 4'b0100,
        W_REG2  = 4'b1000
    } walk_state_t;

    localparam int MUL_A_W   = 14;
    localparam int MUL_P_W   = MUL_A_W + SQ_W;
    localparam int INIT2_END = 4;

    walk_state_t state_reg, state_next;

    logic [COORD_W-1:0]        cx_reg, cy_reg;
    logic [SQ_W-1:0]           rx2_reg, ry2_reg;
    logic [2*SQ_W-1:0]         rxry2_reg;
    logic [GLYPH_W-1:0]        glyph_reg;
    logic [OFS_W-1:0]          x_reg;
    logic signed [OFS_W-1:0]   y_reg;
    logic signed [SLOPE_W-1:0] px_reg, py_reg;
    logic signed [DEC_W-1:0]   p_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [2:0]                step_reg;
    logic [MUL_P_W-1:0]        mul_reg, t1_reg;

    logic                      m_tvalid_reg, m_tlast_reg;
    logic [M_DATA_W-1:0]       m_tdata_reg;

    logic out_free, emit, last_beat;
    logic signed [SLOPE_W-1:0] two_rx2, two_ry2, px_inc, py_dec;
    logic [OFS_W:0]            a_val;
    logic [OFS_W-1:0]          b_abs;
    logic [MUL_A_W-1:0]        mul_a;
    logic [SQ_W-1:0]           mul_b;
    logic signed [DEC_W-1:0]   p2_sum;
    logic signed [OUT_W-1:0]   rxo, lxo, lyo, uyo;
    logic [MASK_W-1:0]         mask;
    logic rx_vis, lx_vis, ly_vis, uy_vis;

    assign out_free = !m_tvalid_reg || m_tready;
    assign q_pop    = (state_reg == W_IDLE) && !q_stat.empty;

    assign two_rx2 = $signed(SLOPE_W'({rx2_reg, 1'b0}));
    assign two_ry2 = $signed(SLOPE_W'({ry2_reg, 1'b0}));
    assign px_inc  = px_reg + two_ry2;
    assign py_dec  = py_reg - two_rx2;

    // Region one emits only while px < py; otherwise it hands over to region two.
    assign emit = out_free && (((state_reg == W_REG1) && (px_reg < py_reg))
                               || (state_reg == W_REG2));
    assign last_beat = (count_reg == CNT_W'(RESULT_CAP - 1))
                       || ((state_reg == W_REG2) && (y_reg == '0));

    // Region-two start value uses one shared multiplier, forming (2x+1)^2*ry^2 and then (y-1)^2*rx^2.
    assign a_val = {x_reg, 1'b1};
    assign b_abs = (y_reg == '0) ? OFS_W'(1) : OFS_W'(y_reg - 1'b1);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            3'd0: begin
                mul_a = MUL_A_W'(a_val);
                mul_b = SQ_W'(a_val);
            end
            3'd1: begin
                mul_a = mul_reg[MUL_A_W-1:0];
                mul_b = ry2_reg;
            end
            3'd2: begin
                mul_a = MUL_A_W'(b_abs);
                mul_b = SQ_W'(b_abs);
            end
            3'd3: begin
                mul_a = mul_reg[MUL_A_W-1:0];
                mul_b = rx2_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign p2_sum = $signed(DEC_W'(t1_reg))
                  + $signed(DEC_W'({mul_reg, 2'b00}))
                  - $signed(DEC_W'({rxry2_reg, 2'b00}));

    // Mirrored coordinates and their visibility.
    assign rxo = $signed(OUT_W'(cx_reg)) + $signed(OUT_W'(x_reg));
    assign lxo = $signed(OUT_W'(cx_reg)) - $signed(OUT_W'(x_reg));
    assign lyo = $signed(OUT_W'(cy_reg)) + OUT_W'(y_reg);
    assign uyo = $signed(OUT_W'(cy_reg)) - OUT_W'(y_reg);
    assign rx_vis = !rxo[OUT_W-1] && (rxo != '0);
    assign lx_vis = !lxo[OUT_W-1] && (lxo != '0);
    assign ly_vis = !lyo[OUT_W-1] && (lyo != '0);
    assign uy_vis = !uyo[OUT_W-1] && (uyo != '0);
    assign mask = {lx_vis && uy_vis, rx_vis && uy_vis, lx_vis && ly_vis, rx_vis && ly_vis};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            W_IDLE:  if (q_pop) state_next = W_REG1;
            W_REG1: begin
                if (px_reg >= py_reg) begin
                    state_next = W_INIT2;
                end else if (emit && last_beat) begin
                    state_next = W_IDLE;
                end
            end
            W_INIT2: if (step_reg == 3'(INIT2_END)) state_next = W_REG2;
            W_REG2:  if (emit && last_beat) state_next = W_IDLE;
            default: state_next = W_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= W_IDLE;
            m_tvalid_reg <= 1'b0;
            count_reg    <= '0;
            step_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (q_pop) begin
                count_reg <= '0;
            end else if (emit) begin
                count_reg <= count_reg + 1'b1;
            end
            if (state_reg == W_INIT2) begin
                step_reg <= step_reg + 1'b1;
            end else begin
                step_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cx_reg    <= q_rdata.cx;
            cy_reg    <= q_rdata.cy;
            rx2_reg   <= q_rdata.rx2;
            ry2_reg   <= q_rdata.ry2;
            rxry2_reg <= q_rdata.rxry2;
            glyph_reg <= q_rdata.glyph;
            x_reg     <= '0;
            y_reg     <= $signed(OFS_W'(q_rdata.ry));
            px_reg    <= '0;
            py_reg    <= q_rdata.py0;
            p_reg     <= q_rdata.p0;
        end else if (emit && (state_reg == W_REG1)) begin
            x_reg  <= x_reg + 1'b1;
            px_reg <= px_inc;
            if (p_reg[DEC_W-1]) begin
                p_reg <= p_reg + $signed(DEC_W'(ry2_reg)) + DEC_W'(px_inc);
            end else begin
                y_reg  <= y_reg - 1'b1;
                py_reg <= py_dec;
                p_reg  <= p_reg + $signed(DEC_W'(ry2_reg)) + DEC_W'(px_inc) - DEC_W'(py_dec);
            end
        end else if (emit && (state_reg == W_REG2)) begin
            y_reg  <= y_reg - 1'b1;
            py_reg <= py_dec;
            if (p_reg > 0) begin
                p_reg <= p_reg + $signed(DEC_W'(rx2_reg)) - DEC_W'(py_dec);
            end else begin
                x_reg  <= x_reg + 1'b1;
                px_reg <= px_inc;
                p_reg  <= p_reg + $signed(DEC_W'(rx2_reg)) - DEC_W'(py_dec) + DEC_W'(px_inc);
            end
        end else if ((state_reg == W_INIT2) && (step_reg == 3'(INIT2_END))) begin
            p_reg <= div4_trunc(p2_sum);
        end

        if (state_reg == W_INIT2) begin
            mul_reg <= mul_a * mul_b;
            if (step_reg == 3'd2) begin
                t1_reg <= mul_reg;
            end
        end

        if (emit) begin
            m_tdata_reg <= {4'b0000, glyph_reg, mask, uyo, lyo, lxo, rxo};
            m_tlast_reg <= last_beat;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

FILE: rtl/midpoint_ellipse_plotter.sv
// Top level of the midpoint ellipse plotter: front end, command queue and walker.
//
// Each input beat is one ellipse command; the block answers with one result beat per
// point group of the two-region midpoint walk, m_tlast marking the final group. The walker
// fetches a command, emits its point groups (at most 63) one per cycle while the result side
// does not stall, leaves region one when it runs out and then forms the region-two decision
// value on its single shared multiplier. The front end takes each command through its idle,
// square, product and push states, waiting in push while the queue is full, and works
// on the next command while the walker is busy; a two-entry queue sits between them.
module midpoint_ellipse_plotter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // center_x[9:0], center_y[19:10], radius_x[24:20],
                                   // radius_y[29:25], glyph[37:30]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // right_x[11:0], left_x[23:12], lower_y[35:24],
                                   // upper_y[47:36], visible_mask[51:48], glyph_out[59:52]
    output logic        m_tlast
);
    import mep_pkg::*;

    mep_cmd_t   q_wdata, q_rdata;
    mep_qstat_t q_stat;
    logic       q_push, q_pop;

    mep_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    mep_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .stat    (q_stat)
    );

    mep_walker u_walker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // The front end never pushes into a full queue, and the walker never pops an empty one.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_push && q_stat.full))
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_pop && q_stat.empty))
        else $error("command popped from an empty queue");

    // A command beat is followed by a busy front end while it forms the squares.
    a_front_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("front end took two command beats in a row");

    // The queue is never both full and empty.
    a_queue_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty at once");

endmodule

FILE: sim/mep_checker.sv
// Checker for the midpoint ellipse plotter: predicts the point groups of every command and compares them.
module mep_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [mep_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [mep_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                         m_tlast,
    output int                           mismatches,
    output int                           groups_pending
);
    import mep_pkg::*;

    localparam int PRINT_LIMIT = 50;

    typedef struct {
        logic signed [OUT_W-1:0] right_x;
        logic signed [OUT_W-1:0] left_x;
        logic signed [OUT_W-1:0] lower_y;
        logic signed [OUT_W-1:0] upper_y;
        logic [MASK_W-1:0]       mask;
        logic [GLYPH_W-1:0]      glyph;
        logic                    last;
    } point_group_t;

    point_group_t point_groups_q[$];
    point_group_t got;
    point_group_t want;
    int           n_mismatch = 0;
    int           n_pending  = 0;
    int           beat_idx   = 0;

    assign mismatches     = n_mismatch;
    assign groups_pending = n_pending;

    task automatic note_mismatch(input string msg);
        if (n_mismatch < PRINT_LIMIT) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
        n_mismatch++;
    endtask

    task automatic check_field(input string name, input int got_val, input int want_val);
        if (got_val != want_val) begin
            note_mismatch($sformatf("result beat %0d: %s is %0d, expected %0d",
                                    beat_idx, name, got_val, want_val));
        end
    endtask

    // The four mirrored points of one offset; a point is visible when both of its
    // coordinates are at least 1.
    function automatic point_group_t make_group(input int cx, input int cy, input int ox,
                                                input int oy, input logic [GLYPH_W-1:0] g);
        point_group_t pg;
        int           xr;
        int           xl;
        int           yl;
        int           yu;
        xr = cx + ox;
        xl = cx - ox;
        yl = cy + oy;
        yu = cy - oy;
        pg.right_x = OUT_W'(xr);
        pg.left_x  = OUT_W'(xl);
        pg.lower_y = OUT_W'(yl);
        pg.upper_y = OUT_W'(yu);
        pg.mask    = {(xl >= 1 && yu >= 1), (xr >= 1 && yu >= 1),
                      (xl >= 1 && yl >= 1), (xr >= 1 && yl >= 1)};
        pg.glyph   = g;
        pg.last    = 1'b0;
        return pg;
    endfunction

    // Two-region midpoint walk of one command. The region start values are formed
    // at four times their size and divided by four, truncating toward zero.
    function automatic void walk_ellipse(input logic [S_DATA_W-1:0] cmd);
        int                 cx;
        int                 cy;
        int                 rx;
        int                 ry;
        int                 rx2;
        int                 ry2;
        int                 ofs_x;
        int                 ofs_y;
        int                 slope_x;
        int                 slope_y;
        int                 dec;
        int                 a;
        int                 b;
        int                 n;
        bit                 region_two;
        logic [GLYPH_W-1:0] g;
        point_group_t       held;
        cx = cmd[9:0];
        cy = cmd[19:10];
        rx = cmd[24:20];
        ry = cmd[29:25];
        g  = cmd[37:30];
        if (cx > COORD_LIM) cx = COORD_LIM;
        if (cy > COORD_LIM) cy = COORD_LIM;
        if (rx > RADIUS_LIM) rx = RADIUS_LIM;
        if (ry > RADIUS_LIM) ry = RADIUS_LIM;
        rx2        = rx * rx;
        ry2        = ry * ry;
        ofs_x      = 0;
        ofs_y      = ry;
        slope_x    = 0;
        slope_y    = 2 * rx2 * ofs_y;
        dec        = (4 * ry2 - 4 * rx2 * ry + rx2) / 4;
        region_two = 1'b0;
        n          = 0;
        while (n < RESULT_CAP) begin
            if (!region_two) begin
                if (slope_x < slope_y) begin
                    if (n > 0) point_groups_q.push_back(held);
                    held = make_group(cx, cy, ofs_x, ofs_y, g);
                    n++;
                    ofs_x++;
                    slope_x += 2 * ry2;
                    if (dec < 0) begin
                        dec += ry2 + slope_x;
                    end else begin
                        ofs_y--;
                        slope_y -= 2 * rx2;
                        dec += ry2 + slope_x - slope_y;
                    end
                end else begin
                    a          = 2 * ofs_x + 1;
                    b          = ofs_y - 1;
                    dec        = (ry2 * a * a + 4 * rx2 * b * b - 4 * rx2 * ry2) / 4;
                    region_two = 1'b1;
                end
            end else begin
                if (ofs_y < 0) break;
                if (n > 0) point_groups_q.push_back(held);
                held = make_group(cx, cy, ofs_x, ofs_y, g);
                n++;
                ofs_y--;
                slope_y -= 2 * rx2;
                if (dec > 0) begin
                    dec += rx2 - slope_y;
                end else begin
                    ofs_x++;
                    slope_x += 2 * ry2;
                    dec += rx2 - slope_y + slope_x;
                end
            end
        end
        // Every command yields at least one group, so the held one closes the ellipse.
        held.last = 1'b1;
        point_groups_q.push_back(held);
    endfunction

    // The command is predicted before the result beat of the same edge is taken, which
    // keeps the order right even for a result that follows at once.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) walk_ellipse(s_tdata);
            if (m_tvalid && m_tready) begin
                if (point_groups_q.size() == 0) begin
                    note_mismatch($sformatf("result beat %0d arrived with none expected: %h",
                                            beat_idx, m_tdata));
                end else begin
                    want        = point_groups_q.pop_front();
                    got.right_x = m_tdata[11:0];
                    got.left_x  = m_tdata[23:12];
                    got.lower_y = m_tdata[35:24];
                    got.upper_y = m_tdata[47:36];
                    got.mask    = m_tdata[51:48];
                    got.glyph   = m_tdata[59:52];
                    got.last    = m_tlast;
                    check_field("right_x", got.right_x, want.right_x);
                    check_field("left_x", got.left_x, want.left_x);
                    check_field("lower_y", got.lower_y, want.lower_y);
                    check_field("upper_y", got.upper_y, want.upper_y);
                    check_field("visible_mask", got.mask, want.mask);
                    check_field("glyph_out", got.glyph, want.glyph);
                    check_field("last", got.last, want.last);
                end
                beat_idx++;
            end
            n_pending <= point_groups_q.size();
        end
    end

endmodule

FILE: sim/testbench.sv
// Top of the midpoint ellipse plotter testbench: clock, reset, command stimulus and verdict.
module testbench;
    import mep_pkg::*;

    localparam int RANDOM_ITEMS    = 300;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 100;
    localparam int CYCLE_LIMIT     = 600000;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    int mismatches;
    int groups_pending;
    int items_sent  = 0;
    int burst_left  = 0;
    int cycle_count = 0;

    midpoint_ellipse_plotter i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    mep_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatches     (mismatches),
        .groups_pending (groups_pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** midpoint_ellipse_plotter: FAILED **");
            $finish;
        end
    end

    // Offers one ellipse command and holds it until the beat is taken. Commands go
    // out in bursts; a gap only follows the end of a burst.
    task automatic send_ellipse(input int cx, input int cy, input int rx, input int ry,
                                input int g);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, GLYPH_W'(g), RADIUS_W'(ry), RADIUS_W'(rx),
                     COORD_W'(cy), COORD_W'(cx)};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
            gap        = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Result side: short random stalls, long stretches without any, and once a long
    // hold-off so that the block backs up and stops taking commands.
    initial begin : results_side
        bit held_off;
        held_off = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held_off && items_sent >= 60) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else if ($urandom_range(0, 9) < 2) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(50, 150)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end
        end
    end

    initial begin : commands_side
        int cx;
        int cy;
        int rx;
        int ry;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Degenerate radii, extreme centres and radii, glyph extremes, and ellipses that
        // straddle the visibility border at coordinate 1.
        send_ellipse(512, 512, 0, 0, 8'h2A);
        send_ellipse(512, 512, 0, 31, 8'h00);
        send_ellipse(512, 512, 31, 0, 8'hFF);
        send_ellipse(512, 512, 31, 31, 8'h55);
        send_ellipse(0, 0, 5, 3, 8'h01);
        send_ellipse(1, 1, 1, 1, 8'h80);
        send_ellipse(1023, 1023, 31, 31, 8'h7F);
        send_ellipse(0, 1023, 31, 7, 8'hAA);
        send_ellipse(1023, 0, 2, 31, 8'hFE);
        send_ellipse(30, 30, 31, 31, 8'h41);
        send_ellipse(31, 31, 30, 29, 8'h23);
        send_ellipse(2, 2, 1, 0, 8'h2E);
        send_ellipse(100, 100, 1, 31, 8'h7C);
        send_ellipse(100, 100, 31, 1, 8'h2D);
        send_ellipse(100, 100, 1, 2, 8'h6F);
        send_ellipse(100, 100, 2, 1, 8'h6F);
        send_ellipse(100, 100, 0, 1, 8'h2B);
        send_ellipse(100, 100, 1, 0, 8'h2B);
        send_ellipse(32, 500, 31, 16, 8'h5C);
        send_ellipse(500, 32, 16, 31, 8'h2F);
        send_ellipse(700, 300, 17, 23, 8'h40);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            case ($urandom_range(0, 3))
                0:       cx = $urandom_range(0, 40);
                1:       cx = $urandom_range(983, 1023);
                default: cx = $urandom_range(0, 1023);
            endcase
            case ($urandom_range(0, 3))
                0:       cy = $urandom_range(0, 40);
                1:       cy = $urandom_range(983, 1023);
                default: cy = $urandom_range(0, 1023);
            endcase
            rx = ($urandom_range(0, 7) == 0) ? 31 * $urandom_range(0, 1) : $urandom_range(0, 31);
            ry = ($urandom_range(0, 7) == 0) ? 31 * $urandom_range(0, 1) : $urandom_range(0, 31);
            send_ellipse(cx, cy, rx, ry, $urandom_range(0, 255));
        end
        s_tvalid <= 1'b0;

        do @(posedge aclk); while (groups_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("** midpoint_ellipse_plotter: PASSED **");
        end else begin
            $display("** midpoint_ellipse_plotter: FAILED **");
        end
        $finish;
    end

endmodule
